### src/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg: shared types and constants of the coordinate converter
// Word layouts between front, back and queues, angle constants, atan table.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int GUARD = 8;
  localparam int XW    = 43;
  localparam int ZW    = 35;

  localparam logic [63:0] PI_Q30     = 64'd3373259426;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  localparam logic signed [ZW-1:0] PI_Z      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Z = 35'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Z  = 35'sd6746518852;

  localparam logic [29:0] INV_GAIN = 30'd652032874;

  typedef enum logic {
    KIND_RECT  = 1'b0,
    KIND_POLAR = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic                  origin;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [ZW-1:0]  z;
  } rot_t;

  typedef struct packed {
    logic signed [31:0] first;
    logic signed [31:0] second;
    logic               sat;
  } res_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h3243F6A8;
      5'd1:    v = 32'h1DAC6705;
      5'd2:    v = 32'h0FADBAFC;
      5'd3:    v = 32'h07F56EA6;
      5'd4:    v = 32'h03FEAB76;
      5'd5:    v = 32'h01FFD55B;
      5'd6:    v = 32'h00FFFAAA;
      5'd7:    v = 32'h007FFF55;
      5'd8:    v = 32'h003FFFEA;
      5'd9:    v = 32'h001FFFFD;
      5'd10:   v = 32'h000FFFFF;
      5'd11:   v = 32'h0007FFFF;
      5'd12:   v = 32'h0003FFFF;
      5'd13:   v = 32'h0001FFFF;
      5'd14:   v = 32'h0000FFFF;
      5'd15:   v = 32'h00007FFF;
      5'd16:   v = 32'h00003FFF;
      5'd17:   v = 32'h00001FFF;
      5'd18:   v = 32'h00000FFF;
      5'd19:   v = 32'h000007FF;
      5'd20:   v = 32'h000003FF;
      5'd21:   v = 32'h000001FF;
      5'd22:   v = 32'h000000FF;
      5'd23:   v = 32'h0000007F;
      5'd24:   v = 32'h0000003F;
      5'd25:   v = 32'h0000001F;
      5'd26:   v = 32'h0000000F;
      5'd27:   v = 32'h00000008;
      5'd28:   v = 32'h00000004;
      5'd29:   v = 32'h00000002;
      default: v = 32'h00000000;
    endcase
    return $signed({{(ZW-32){1'b0}}, v});
  endfunction

endpackage

### src/cartesian_polar_converter_core.sv
// ----------------------------------------------------------------------------
// cartesian_polar_converter_core: rectangular/polar conversion by CORDIC
// Sustains one item per clock while neither queue is full. From accept to
// result an item passes one capture stage, one stage per quotient bit of
// the 2*pi angle reduction (29 - FRACTION_BITS), one stage per CORDIC
// iteration, three gain-removal stages and the two two-word queues.
// A stalled result side freezes the back pipeline; the front keeps going
// until the middle queue fills.
// ----------------------------------------------------------------------------
module cartesian_polar_converter_core #(
  parameter int ITERATIONS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               kind_i,
  input  logic signed [31:0] first_in_i,
  input  logic signed [31:0] second_in_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] first_out_o,
  output logic signed [31:0] second_out_o,
  output logic               saturated_o
);

  localparam int ROT_W = $bits(cpc_pkg::rot_t);
  localparam int RES_W = $bits(cpc_pkg::res_t);

  logic             mid_full, mid_empty, mid_push, mid_pop;
  cpc_pkg::rot_t    mid_wr, mid_rd;
  logic [ROT_W-1:0] mid_rd_w;
  logic             out_full, out_push;
  cpc_pkg::res_t    out_wr, out_rd;
  logic [RES_W-1:0] out_rd_w;

  assign full = mid_full;

  cpc_front #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (!mid_full),
    .valid_i  (push && !mid_full),
    .kind_i   (cpc_pkg::kind_e'(kind_i)),
    .first_i  (first_in_i),
    .second_i (second_in_i),
    .push_o   (mid_push),
    .item_o   (mid_wr)
  );

  cpc_fifo #(
    .WIDTH (ROT_W),
    .DEPTH (2)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wr),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rd_w),
    .empty_o (mid_empty)
  );

  assign mid_rd = cpc_pkg::rot_t'(mid_rd_w);

  cpc_back #(
    .ITERATIONS    (ITERATIONS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (!out_full),
    .valid_i (!mid_empty),
    .item_i  (mid_rd),
    .pop_o   (mid_pop),
    .push_o  (out_push),
    .item_o  (out_wr)
  );

  cpc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wr),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_rd_w),
    .empty_o (empty)
  );

  assign out_rd       = cpc_pkg::res_t'(out_rd_w);
  assign first_out_o  = out_rd.first;
  assign second_out_o = out_rd.second;
  assign saturated_o  = out_rd.sat;

endmodule

### src/cpc_fifo.sv
// ----------------------------------------------------------------------------
// cpc_fifo: short register queue
// Push/pop queue built from flops; head word is shown while not empty.
// ----------------------------------------------------------------------------
module cpc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

### src/cpc_front.sv
// ----------------------------------------------------------------------------
// cpc_front: accept and classify
// Reduces polar angles modulo 2*pi one quotient bit per stage, then picks
// the quadrant pre-rotation and hands a rotation word to the queue.
// ----------------------------------------------------------------------------
module cpc_front #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  cpc_pkg::kind_e      kind_i,
  input  logic signed [31:0]  first_i,
  input  logic signed [31:0]  second_i,
  output logic                push_o,
  output cpc_pkg::rot_t       item_o
);

  localparam int SHIFT = 30 - FRACTION_BITS;
  localparam int QBITS = 29 - FRACTION_BITS;
  localparam int MAG_W = 62 - FRACTION_BITS;
  localparam int XW    = cpc_pkg::XW;
  localparam int ZW    = cpc_pkg::ZW;

  typedef struct packed {
    cpc_pkg::kind_e      kind;
    logic                neg;
    logic [MAG_W-1:0]    mag;
    logic signed [31:0]  p;
    logic signed [31:0]  q;
  } red_t;

  red_t        s_q   [QBITS+1];
  logic        vld_q [QBITS+1];
  red_t        nxt   [QBITS];
  red_t        s_in;
  logic [31:0] absq;

  assign absq = second_i[31] ? (~second_i + 32'd1) : second_i;

  always_comb begin
    s_in.kind = kind_i;
    s_in.neg  = second_i[31];
    s_in.mag  = MAG_W'(absq) << SHIFT;
    s_in.p    = first_i;
    s_in.q    = second_i;
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_red
    localparam logic [63:0] CK = cpc_pkg::TWO_PI_Q30 << (QBITS - 1 - k);
    always_comb begin
      nxt[k] = s_q[k];
      if (s_q[k].mag >= CK[MAG_W-1:0]) begin
        nxt[k].mag = s_q[k].mag - CK[MAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QBITS; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 0; k < QBITS; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0] <= s_in;
      for (int k = 0; k < QBITS; k++) begin
        s_q[k+1] <= nxt[k];
      end
    end
  end

  red_t                 fin;
  logic signed [ZW-1:0] rem, th0, th;
  logic signed [XW-1:0] gp, gq;

  assign fin    = s_q[QBITS];
  assign push_o = en_i && vld_q[QBITS];

  always_comb begin
    rem = $signed({1'b0, fin.mag[ZW-2:0]});
    th0 = fin.neg ? -rem : rem;
    if (th0 > cpc_pkg::PI_Z) begin
      th = th0 - cpc_pkg::TWO_PI_Z;
    end else if (th0 < -cpc_pkg::PI_Z) begin
      th = th0 + cpc_pkg::TWO_PI_Z;
    end else begin
      th = th0;
    end
    gp = $signed({{(XW-32-cpc_pkg::GUARD){fin.p[31]}}, fin.p, {cpc_pkg::GUARD{1'b0}}});
    gq = $signed({{(XW-32-cpc_pkg::GUARD){fin.q[31]}}, fin.q, {cpc_pkg::GUARD{1'b0}}});

    item_o.kind   = fin.kind;
    item_o.origin = 1'b0;
    item_o.x      = gp;
    item_o.y      = '0;
    item_o.z      = th;
    case (fin.kind)
      cpc_pkg::KIND_RECT: begin
        item_o.origin = (fin.p == '0) && (fin.q == '0);
        if (!fin.p[31]) begin
          item_o.x = gp;
          item_o.y = gq;
          item_o.z = '0;
        end else if (!fin.q[31]) begin
          item_o.x = gq;
          item_o.y = -gp;
          item_o.z = cpc_pkg::HALF_PI_Z;
        end else begin
          item_o.x = -gq;
          item_o.y = gp;
          item_o.z = -cpc_pkg::HALF_PI_Z;
        end
      end
      cpc_pkg::KIND_POLAR: begin
        if (th > cpc_pkg::HALF_PI_Z) begin
          item_o.x = '0;
          item_o.y = gp;
          item_o.z = th - cpc_pkg::HALF_PI_Z;
        end else if (th < -cpc_pkg::HALF_PI_Z) begin
          item_o.x = '0;
          item_o.y = -gp;
          item_o.z = th + cpc_pkg::HALF_PI_Z;
        end else begin
          item_o.x = gp;
          item_o.y = '0;
          item_o.z = th;
        end
      end
      default: begin
        item_o.x = gp;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_polar_residual: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && item_o.kind == cpc_pkg::KIND_POLAR) |->
      (item_o.z <= cpc_pkg::HALF_PI_Z && item_o.z >= -cpc_pkg::HALF_PI_Z))
    else $error("polar residual angle outside half pi");
  a_polar_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && item_o.kind == cpc_pkg::KIND_POLAR) |->
      (item_o.x == '0 || item_o.y == '0))
    else $error("polar start vector off axis");
`endif

endmodule

### src/cpc_back.sv
// ----------------------------------------------------------------------------
// cpc_back: CORDIC execution
// One rotation stage per iteration, then gain removal, rounding, clamping
// and angle scaling into a result word.
// ----------------------------------------------------------------------------
module cpc_back #(
  parameter int ITERATIONS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  cpc_pkg::rot_t  item_i,
  output logic           pop_o,
  output logic           push_o,
  output cpc_pkg::res_t  item_o
);

  localparam int XW    = cpc_pkg::XW;
  localparam int ZW    = cpc_pkg::ZW;
  localparam int SHIFT = 30 - FRACTION_BITS;
  localparam int HW    = XW - 16 + 30;
  localparam int MW    = HW - 21;
  localparam logic signed [ZW-1:0] HALF_S = ZW'(1) << (SHIFT - 1);
  localparam logic [63:0] PI_F64 = (cpc_pkg::PI_Q30 + (64'd1 << (SHIFT - 1))) >> SHIFT;
  localparam logic signed [ZW-1:0] PI_F = $signed(PI_F64[ZW-1:0]);
  localparam logic [MW-1:0] POS_MAX = MW'(32'h7FFFFFFF);
  localparam logic [MW-1:0] NEG_MAX = MW'(33'h080000000);

  cpc_pkg::rot_t cur   [ITERATIONS];
  cpc_pkg::rot_t rot   [ITERATIONS];
  cpc_pkg::rot_t st_q  [ITERATIONS];
  logic          vld_q [ITERATIONS];

  assign pop_o = en_i && valid_i;

  always_comb begin
    cur[0] = item_i;
    for (int i = 1; i < ITERATIONS; i++) begin
      cur[i] = st_q[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < ITERATIONS; i++) begin
      logic                 plus;
      logic signed [XW-1:0] xs, ys;
      logic signed [ZW-1:0] az;
      plus = (cur[i].kind == cpc_pkg::KIND_RECT) ? !cur[i].y[XW-1] : cur[i].z[ZW-1];
      xs   = cur[i].x >>> i;
      ys   = cur[i].y >>> i;
      az   = cpc_pkg::atan_q30(5'(i));
      rot[i] = cur[i];
      if (plus) begin
        rot[i].x = cur[i].x + ys;
        rot[i].y = cur[i].y - xs;
        rot[i].z = cur[i].z + az;
      end else begin
        rot[i].x = cur[i].x - ys;
        rot[i].y = cur[i].y + xs;
        rot[i].z = cur[i].z - az;
      end
    end
  end

  // gain removal pipeline
  logic                 u1_vld_q, u2_vld_q, u3_vld_q;
  cpc_pkg::kind_e       u1_kind_q, u2_kind_q, u3_kind_q;
  logic                 u1_org_q, u2_org_q, u3_org_q;
  logic                 u1_sx_q, u1_sy_q, u2_sx_q, u2_sy_q, u3_sx_q, u3_sy_q;
  logic [XW-1:0]        u1_ax_q, u1_ay_q;
  logic signed [ZW-1:0] u1_z_q, u2_z_q;
  logic [HW-1:0]        u2_hx_q, u2_hy_q;
  logic [29:0]          u2_lx_q, u2_ly_q;
  logic [MW-1:0]        u3_mx_q, u3_my_q;
  logic signed [ZW-1:0] u3_ang_q;

  cpc_pkg::rot_t        last;
  logic [45:0]          plx, ply;
  logic [HW:0]          sumx, sumy;
  logic signed [ZW-1:0] angr;

  assign last = st_q[ITERATIONS-1];
  assign plx  = 46'(u1_ax_q[15:0]) * 46'(cpc_pkg::INV_GAIN);
  assign ply  = 46'(u1_ay_q[15:0]) * 46'(cpc_pkg::INV_GAIN);
  assign sumx = (HW+1)'(u2_hx_q) + (HW+1)'(u2_lx_q) + ((HW+1)'(1) << 21);
  assign sumy = (HW+1)'(u2_hy_q) + (HW+1)'(u2_ly_q) + ((HW+1)'(1) << 21);
  assign angr = (u2_z_q + HALF_S) >>> SHIFT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ITERATIONS; i++) begin
        vld_q[i] <= 1'b0;
      end
      u1_vld_q <= 1'b0;
      u2_vld_q <= 1'b0;
      u3_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= pop_o;
      for (int i = 1; i < ITERATIONS; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      u1_vld_q <= vld_q[ITERATIONS-1];
      u2_vld_q <= u1_vld_q;
      u3_vld_q <= u2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < ITERATIONS; i++) begin
        st_q[i] <= rot[i];
      end
      u1_kind_q <= last.kind;
      u1_org_q  <= last.origin;
      u1_sx_q   <= last.x[XW-1];
      u1_sy_q   <= last.y[XW-1];
      u1_ax_q   <= last.x[XW-1] ? (~last.x + XW'(1)) : last.x;
      u1_ay_q   <= last.y[XW-1] ? (~last.y + XW'(1)) : last.y;
      u1_z_q    <= last.z;

      u2_kind_q <= u1_kind_q;
      u2_org_q  <= u1_org_q;
      u2_sx_q   <= u1_sx_q;
      u2_sy_q   <= u1_sy_q;
      u2_hx_q   <= HW'(u1_ax_q[XW-1:16]) * HW'(cpc_pkg::INV_GAIN);
      u2_hy_q   <= HW'(u1_ay_q[XW-1:16]) * HW'(cpc_pkg::INV_GAIN);
      u2_lx_q   <= plx[45:16];
      u2_ly_q   <= ply[45:16];
      u2_z_q    <= u1_z_q;

      u3_kind_q <= u2_kind_q;
      u3_org_q  <= u2_org_q;
      u3_sx_q   <= u2_sx_q;
      u3_sy_q   <= u2_sy_q;
      u3_mx_q   <= sumx[HW:22];
      u3_my_q   <= sumy[HW:22];
      u3_ang_q  <= angr;
    end
  end

  logic               satx, saty;
  logic signed [31:0] cx, cy, ca;

  always_comb begin
    satx = u3_sx_q ? (u3_mx_q > NEG_MAX) : (u3_mx_q > POS_MAX);
    saty = u3_sy_q ? (u3_my_q > NEG_MAX) : (u3_my_q > POS_MAX);
    if (satx) begin
      cx = u3_sx_q ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      cx = u3_sx_q ? -$signed(u3_mx_q[31:0]) : $signed(u3_mx_q[31:0]);
    end
    if (saty) begin
      cy = u3_sy_q ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      cy = u3_sy_q ? -$signed(u3_my_q[31:0]) : $signed(u3_my_q[31:0]);
    end
    if (u3_ang_q > PI_F) begin
      ca = PI_F[31:0];
    end else if (u3_ang_q < -PI_F) begin
      ca = -PI_F[31:0];
    end else begin
      ca = u3_ang_q[31:0];
    end

    case (u3_kind_q)
      cpc_pkg::KIND_RECT: begin
        if (u3_org_q) begin
          item_o.first  = '0;
          item_o.second = '0;
          item_o.sat    = 1'b0;
        end else begin
          item_o.first  = cx;
          item_o.second = ca;
          item_o.sat    = satx;
        end
      end
      cpc_pkg::KIND_POLAR: begin
        item_o.first  = cx;
        item_o.second = cy;
        item_o.sat    = satx || saty;
      end
      default: begin
        item_o.first  = cx;
        item_o.second = cy;
        item_o.sat    = satx;
      end
    endcase
  end

  assign push_o = en_i && u3_vld_q;

`ifndef NO_ASSERTIONS
  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && item_o.sat) |->
      (item_o.first == 32'sh7FFFFFFF || item_o.first == 32'sh80000000 ||
       item_o.second == 32'sh7FFFFFFF || item_o.second == 32'sh80000000))
    else $error("saturation flag without clipped value");
  a_origin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && u3_kind_q == cpc_pkg::KIND_RECT && u3_org_q) |->
      (item_o.first == '0 && item_o.second == '0 && !item_o.sat))
    else $error("origin did not give zero result");
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && u3_kind_q == cpc_pkg::KIND_RECT) |->
      ($signed(item_o.second) <= $signed(PI_F[31:0]) &&
       $signed(item_o.second) >= -$signed(PI_F[31:0])))
    else $error("angle outside pi range");
`endif

endmodule
